[design/ttce_pkg.sv]
// Shared constants for the character-cell terminal cursor engine.
// No dependencies; imported by text_terminal_cursor_engine_top.
`default_nettype none

package ttce_pkg;

    // Default screen geometry in character cells.
    localparam int COLUMNS_DEF = 40;
    localparam int ROWS_DEF    = 15;

    // Width of the shared step unit; holds any column or row count up to 255.
    localparam int UNIT_W = 8;

    // Display command codes.
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;

    // Control characters and the blanking glyph.
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Configuration register indexes.
    localparam logic [1:0] REG_WRAP    = 2'd0;
    localparam logic [1:0] REG_SCROLL  = 2'd1;
    localparam logic [1:0] REG_OVERLAY = 2'd2;

endpackage

`default_nettype wire

[design/text_terminal_cursor_engine_top.sv]
// Terminal cursor engine: turns character bytes into cell display commands.
// Depends on ttce_pkg for command codes, character codes and defaults.
//
// Usage:
// - Input channel (i_valid / o_ready / i_character) takes one character
//   word. The block is ready only while its sequencer is idle, so one
//   character is worked on at a time.
// - Output channel (o_valid / i_ready) delivers command words (draw, clear
//   to end of row, scroll) from a single output register; the final word
//   caused by a character has o_last set. Some characters give no word.
// - Every step goes through one shared 8-bit increment/decrement and
//   compare unit, used for the column on draws and backspace and for the
//   row on line feeds. A draw run returns to idle once its count is spent
//   or the column is clipped, and a wrap or a newline adds a line move.
// - When the receiver stalls, the word waits in the output register and
//   the sequencer holds before its next emission; a new character can be
//   accepted while the last word of the previous one still waits.
// - Configuration writes (i_cfg_we) take effect at once and are meant for
//   idle periods. Reset (synchronous, active low) homes the cursor, enables
//   wrap and scroll, clears overlay mode and empties the output register.
`default_nettype none

module text_terminal_cursor_engine_top #(
    parameter int COLUMNS = ttce_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttce_pkg::ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // character input
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_character,
    // command output
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_command,
    output logic [5:0]      o_column,
    output logic [3:0]      o_row,
    output logic [7:0]      o_glyph,
    output logic            o_last,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic       i_cfg_data
);

    import ttce_pkg::*;

    // The column may sit one past the last cell when wrap is off.
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int RW = $clog2(ROWS);
    localparam logic [UNIT_W-1:0] COL_LIM  = UNIT_W'(COLUMNS);
    localparam logic [UNIT_W-1:0] ROW_LIM  = UNIT_W'(ROWS);
    localparam logic [UNIT_W-1:0] ROW_LAST = UNIT_W'(ROWS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PUT  = 5'b00010,
        S_DOWN = 5'b00100,
        S_BS   = 5'b01000,
        S_NL   = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [2:0]      r_cnt, n_cnt;
    logic [7:0]      r_glyph, n_glyph;
    logic            r_wrap_en, r_scroll_en, r_overlay;

    logic            r_out_valid;
    logic [1:0]      r_out_cmd;
    logic [UNIT_W-1:0] r_out_col;
    logic [UNIT_W-1:0] r_out_row;
    logic [7:0]      r_out_glyph;
    logic            r_out_last;

    logic            w_emit;
    logic [1:0]      w_emit_cmd;
    logic [UNIT_W-1:0] w_emit_col;
    logic [UNIT_W-1:0] w_emit_row;
    logic [7:0]      w_emit_glyph;
    logic            w_emit_last;

    logic            w_free;
    logic            w_accept;
    logic            w_dec;
    logic [UNIT_W-1:0] w_op, w_lim, w_sum;
    logic            w_hit;
    logic            w_col_end;
    logic            w_row_last;
    logic            w_wrapped;
    logic            w_scroll_next;
    logic            w_clear;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_free   = !r_out_valid || i_ready;

    // Shared step unit: +1 or -1 on the column or the row, compared
    // against the matching screen limit.
    assign w_dec = (r_state == S_BS);
    assign w_op  = (r_state == S_DOWN) ? UNIT_W'(r_row) : UNIT_W'(r_col);
    assign w_lim = (r_state == S_DOWN) ? ROW_LIM : COL_LIM;
    assign w_sum = w_dec ? (w_op - UNIT_W'(1)) : (w_op + UNIT_W'(1));
    assign w_hit = (w_sum == w_lim);

    assign w_col_end  = (UNIT_W'(r_col) == COL_LIM);
    assign w_row_last = (UNIT_W'(r_row) == ROW_LAST);
    assign w_wrapped     = r_wrap_en && w_hit;
    assign w_scroll_next = w_wrapped && w_row_last && r_scroll_en;
    assign w_clear       = !r_overlay && !w_col_end;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_cnt        = r_cnt;
        n_glyph      = r_glyph;
        w_emit       = 1'b0;
        w_emit_cmd   = CMD_DRAW;
        w_emit_col   = UNIT_W'(r_col);
        w_emit_row   = UNIT_W'(r_row);
        w_emit_glyph = r_glyph;
        w_emit_last  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_character)
                        CHAR_BS: begin
                            if (r_col != '0) begin
                                n_state = S_BS;
                            end
                        end
                        CHAR_TAB: begin
                            // Spaces up to one cell before the next tab stop.
                            n_cnt   = 3'd7 - r_col[2:0];
                            n_glyph = CHAR_SPACE;
                            if (r_col[2:0] != 3'd7) begin
                                n_state = S_PUT;
                            end
                        end
                        CHAR_NL: begin
                            n_state = S_NL;
                        end
                        CHAR_CR: begin
                            n_col = '0;
                        end
                        default: begin
                            n_cnt   = 3'd1;
                            n_glyph = i_character;
                            n_state = S_PUT;
                        end
                    endcase
                end
            end

            S_PUT: begin
                if (r_cnt == 3'd0 || w_col_end) begin
                    // Nothing left, or clipped at the right edge.
                    n_state = S_IDLE;
                end else if (w_free) begin
                    w_emit      = 1'b1;
                    w_emit_cmd  = CMD_DRAW;
                    w_emit_last = (r_cnt == 3'd1 || (!r_wrap_en && w_hit)) &&
                                  !w_scroll_next;
                    n_cnt       = r_cnt - 3'd1;
                    if (w_wrapped) begin
                        n_col   = '0;
                        n_state = S_DOWN;
                    end else begin
                        n_col   = CW'(w_sum);
                    end
                end
            end

            S_DOWN: begin
                if (w_hit) begin
                    if (r_scroll_en) begin
                        if (w_free) begin
                            w_emit       = 1'b1;
                            w_emit_cmd   = CMD_SCROLL;
                            w_emit_col   = '0;
                            w_emit_row   = ROW_LAST;
                            w_emit_glyph = CHAR_SPACE;
                            w_emit_last  = (r_cnt == 3'd0);
                            n_state      = S_PUT;
                        end
                    end else begin
                        n_row   = '0;
                        n_state = S_PUT;
                    end
                end else begin
                    n_row   = RW'(w_sum);
                    n_state = S_PUT;
                end
            end

            S_BS: begin
                if (w_free) begin
                    w_emit       = 1'b1;
                    w_emit_cmd   = CMD_DRAW;
                    w_emit_col   = w_sum;
                    w_emit_glyph = CHAR_SPACE;
                    w_emit_last  = 1'b1;
                    n_col        = CW'(w_sum);
                    n_state      = S_IDLE;
                end
            end

            S_NL: begin
                if (!w_clear || w_free) begin
                    w_emit       = w_clear;
                    w_emit_cmd   = CMD_CLEAR;
                    w_emit_glyph = CHAR_SPACE;
                    w_emit_last  = !(w_row_last && r_scroll_en);
                    n_col        = '0;
                    n_cnt        = 3'd0;
                    n_state      = S_DOWN;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_wrap_en   <= 1'b1;
            r_scroll_en <= 1'b1;
            r_overlay   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WRAP:    r_wrap_en   <= i_cfg_data;
                    REG_SCROLL:  r_scroll_en <= i_cfg_data;
                    REG_OVERLAY: r_overlay   <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        if (w_emit) begin
            r_out_cmd   <= w_emit_cmd;
            r_out_col   <= w_emit_col;
            r_out_row   <= w_emit_row;
            r_out_glyph <= w_emit_glyph;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_command = r_out_cmd;
    assign o_column  = r_out_col[5:0];
    assign o_row     = r_out_row[3:0];
    assign o_glyph   = r_out_glyph;
    assign o_last    = r_out_last;

    // The cursor never runs past one column beyond the right edge.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UNIT_W'(r_col) <= COL_LIM)
        else $error("cursor column beyond screen width");

    // The cursor row always names a row of the screen.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UNIT_W'(r_row) < ROW_LIM)
        else $error("cursor row beyond screen height");

    // A carriage return homes the column register once it is taken.
    a_cr_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_character == CHAR_CR) |=> (r_col == '0))
        else $error("carriage return did not home the column");

endmodule

`default_nettype wire
